/* design/dhcp_option_parser_defines.svh */
// ----------------------------------------------------------------------------
// DHCP option parser assertion macros
// Shared concurrent assertion wrappers; they compile away under SYNTHESIS.
// ----------------------------------------------------------------------------
`ifndef DHCP_OPTION_PARSER_DEFINES_SVH
`define DHCP_OPTION_PARSER_DEFINES_SVH

`ifndef SYNTHESIS

// Same-cycle implication, checked outside reset
`define DOP_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked outside reset
`define DOP_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`else

`define DOP_ASSERT_IMP(lbl, ante, cons, msg)
`define DOP_ASSERT_NXT(lbl, ante, cons, msg)

`endif

`endif

/* design/dop_pkg.sv */
// ----------------------------------------------------------------------------
// DHCP option parser package
// Option codes, parse phase and status types, word slot decode.
// ----------------------------------------------------------------------------
`default_nettype none

package dop_pkg;

	// Option codes of interest
	localparam logic [7:0] CODE_PAD     = 8'd0;
	localparam logic [7:0] CODE_SUBNET  = 8'd1;
	localparam logic [7:0] CODE_ROUTER  = 8'd3;
	localparam logic [7:0] CODE_LEASE   = 8'd51;
	localparam logic [7:0] CODE_MSGTYPE = 8'd53;
	localparam logic [7:0] CODE_SERVER  = 8'd54;
	localparam logic [7:0] CODE_END     = 8'd255;

	// Bytes captured from a four-byte option
	localparam logic [2:0] WORD_BYTES = 3'd4;

	// Found-mask bit of the message type
	localparam int unsigned FOUND_TYPE_BIT = 4;

	// Record walker phase, one-hot
	typedef enum logic [3:0] {
		PH_CODE  = 4'b0001,
		PH_LEN   = 4'b0010,
		PH_VALUE = 4'b0100,
		PH_DONE  = 4'b1000
	} phase_t;

	// Result status
	typedef enum logic [1:0] {
		ST_END_CODE  = 2'd0,
		ST_NO_END    = 2'd1,
		ST_IN_RECORD = 2'd2
	} status_t;

	// Captured word slot for a four-byte option
	typedef struct packed {
		logic       hit;
		logic [1:0] idx;
	} slot_t;

	function automatic slot_t word_slot(input logic [7:0] code);
		slot_t s;
		s.hit = 1'b1;
		s.idx = 2'd0;
		unique case (code)
			CODE_SUBNET: s.idx = 2'd0;
			CODE_ROUTER: s.idx = 2'd1;
			CODE_SERVER: s.idx = 2'd2;
			CODE_LEASE:  s.idx = 2'd3;
			default:     s.hit = 1'b0;
		endcase
		return s;
	endfunction

endpackage

`default_nettype wire

/* design/dhcp_option_parser.sv */
// ----------------------------------------------------------------------------
// DHCP option parser
// Walks the code-length-value records of a DHCP options area and reports
// subnet mask, first router, server identifier, lease time and message type.
// ----------------------------------------------------------------------------
// One byte of the options area is taken per beat, one beat per cycle while
// in_stall is low. A beat is held in an input register, then the record
// walker updates its state and, on the end code or on the final byte of the
// area, loads the result register. The input side stalls only when a beat
// would make a result while the previous result is still held by a stalled
// output. Pad bytes are skipped, unknown options are skipped by their length,
// and bytes after the end code are ignored until last_byte; after last_byte
// all parse state returns to its reset value for the next area. A field that
// was not found reads as zero, and the found mask tells which fields are
// present.
`default_nettype none

`include "dhcp_option_parser_defines.svh"

module dhcp_option_parser (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// Input byte channel
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [7:0]  option_byte,
	input  wire logic        last_byte,
	// Result channel
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [31:0]      subnet_mask,
	output logic [31:0]      router_addr,
	output logic [31:0]      server_addr,
	output logic [31:0]      lease_seconds,
	output logic [7:0]       message_type,
	output logic [4:0]       found_mask,
	output logic [1:0]       parse_status
);

	// Input register
	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       last_s1;

	// Parse state
	dop_pkg::phase_t phase_q;
	logic [7:0]      code_q;
	logic [7:0]      left_q;
	logic [2:0]      idx_q;
	logic [31:0]     acc_q;
	logic [31:0]     words_q [4];
	logic [7:0]      type_q;
	logic [4:0]      found_q;

	// Next state
	dop_pkg::phase_t phase_n;
	logic [7:0]      code_n;
	logic [7:0]      left_n;
	logic [2:0]      idx_n;
	logic [31:0]     acc_n;
	logic [31:0]     words_n [4];
	logic [7:0]      type_n;
	logic [4:0]      found_n;

	// Result register
	logic             out_valid_q;
	logic [31:0]      res_words_q [4];
	logic [7:0]       res_type_q;
	logic [4:0]       res_found_q;
	dop_pkg::status_t res_status_q;

	dop_pkg::slot_t   slot;
	logic             emit_end;
	logic             emit_last;
	logic             emit;
	dop_pkg::status_t status_n;
	logic             out_hold;
	logic             advance;
	logic             accept;

	// Handshake: a beat moves on unless it makes a result that cannot be stored
	assign out_hold = out_valid_q && out_stall;
	assign advance  = valid_s1 && (!emit || !out_hold);
	assign in_stall = valid_s1 && !advance;
	assign accept   = in_valid && !in_stall;

	assign slot = dop_pkg::word_slot(code_q);

	// Record walker
	always_comb begin
		phase_n  = phase_q;
		code_n   = code_q;
		left_n   = left_q;
		idx_n    = idx_q;
		acc_n    = acc_q;
		words_n  = words_q;
		type_n   = type_q;
		found_n  = found_q;
		emit_end = 1'b0;
		unique case (phase_q)
			dop_pkg::PH_CODE: begin
				if (byte_s1 == dop_pkg::CODE_END) begin
					emit_end = 1'b1;
					phase_n  = dop_pkg::PH_DONE;
				end else if (byte_s1 != dop_pkg::CODE_PAD) begin
					code_n  = byte_s1;
					phase_n = dop_pkg::PH_LEN;
				end
			end
			dop_pkg::PH_LEN: begin
				left_n  = byte_s1;
				idx_n   = 3'd0;
				acc_n   = 32'd0;
				phase_n = (byte_s1 == 8'd0) ? dop_pkg::PH_CODE : dop_pkg::PH_VALUE;
			end
			dop_pkg::PH_VALUE: begin
				// message type keeps its first occurrence
				if (idx_q == 3'd0 && code_q == dop_pkg::CODE_MSGTYPE &&
						!found_q[dop_pkg::FOUND_TYPE_BIT]) begin
					type_n = byte_s1;
					found_n[dop_pkg::FOUND_TYPE_BIT] = 1'b1;
				end
				// big-endian assembly of the first four value bytes
				if (idx_q < dop_pkg::WORD_BYTES) begin
					acc_n = {acc_q[23:0], byte_s1};
					idx_n = idx_q + 3'd1;
					if (idx_n == dop_pkg::WORD_BYTES && slot.hit) begin
						words_n[slot.idx] = acc_n;
						found_n[slot.idx] = 1'b1;
					end
				end
				left_n = left_q - 8'd1;
				if (left_q == 8'd1) begin
					phase_n = dop_pkg::PH_CODE;
					left_n  = 8'd0;
					idx_n   = 3'd0;
					acc_n   = 32'd0;
				end
			end
			dop_pkg::PH_DONE: begin
				// trailing bytes ignored
			end
			default: begin
				phase_n = dop_pkg::PH_CODE;
			end
		endcase
	end

	// Result decision
	assign emit_last = last_s1 && !emit_end && (phase_n != dop_pkg::PH_DONE);
	assign emit      = emit_end || emit_last;

	always_comb begin
		priority if (emit_end) begin
			status_n = dop_pkg::ST_END_CODE;
		end else if (phase_n == dop_pkg::PH_CODE) begin
			status_n = dop_pkg::ST_NO_END;
		end else begin
			status_n = dop_pkg::ST_IN_RECORD;
		end
	end

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			byte_s1 <= option_byte;
			last_s1 <= last_byte;
		end
	end

	// Parse state; the final byte of an area returns everything to reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= dop_pkg::PH_CODE;
			code_q  <= 8'd0;
			left_q  <= 8'd0;
			idx_q   <= 3'd0;
			acc_q   <= 32'd0;
			words_q <= '{default: 32'd0};
			type_q  <= 8'd0;
			found_q <= 5'd0;
		end else if (advance) begin
			if (last_s1) begin
				phase_q <= dop_pkg::PH_CODE;
				code_q  <= 8'd0;
				left_q  <= 8'd0;
				idx_q   <= 3'd0;
				acc_q   <= 32'd0;
				words_q <= '{default: 32'd0};
				type_q  <= 8'd0;
				found_q <= 5'd0;
			end else begin
				phase_q <= phase_n;
				code_q  <= code_n;
				left_q  <= left_n;
				idx_q   <= idx_n;
				acc_q   <= acc_n;
				words_q <= words_n;
				type_q  <= type_n;
				found_q <= found_n;
			end
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && emit) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && emit) begin
			res_words_q  <= words_n;
			res_type_q   <= type_n;
			res_found_q  <= found_n;
			res_status_q <= status_n;
		end
	end

	assign out_valid     = out_valid_q;
	assign subnet_mask   = res_words_q[0];
	assign router_addr   = res_words_q[1];
	assign server_addr   = res_words_q[2];
	assign lease_seconds = res_words_q[3];
	assign message_type  = res_type_q;
	assign found_mask    = res_found_q;
	assign parse_status  = res_status_q;

	// Checks
	`DOP_ASSERT_IMP(a_value_has_bytes, phase_q == dop_pkg::PH_VALUE, left_q != 8'd0, "value phase with no bytes left")
	`DOP_ASSERT_IMP(a_idx_range, 1'b1, idx_q <= dop_pkg::WORD_BYTES, "value index past word")
	`DOP_ASSERT_NXT(a_area_reset, advance && last_s1, phase_q == dop_pkg::PH_CODE && found_q == 5'd0, "state not cleared after area end")
	`DOP_ASSERT_IMP(a_type_zero, out_valid_q && !res_found_q[dop_pkg::FOUND_TYPE_BIT], res_type_q == 8'd0, "message type set without found bit")
	`DOP_ASSERT_IMP(a_no_overwrite, valid_s1 && emit && out_hold, in_stall && !advance, "result would overwrite a held result")

endmodule

`default_nettype wire
